// ===== rtl/e2n_pkg.sv =====
// Shared constants and tables for the ECEF to NED rotation unit.
`default_nettype none
package e2n_pkg;
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REF_LATITUDE  = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REF_LONGITUDE = 8'd1;
   localparam longint GAIN_Q30 = 64'd652032874;
   localparam int ATAN_INDEX_WIDTH = 6;
   localparam int ANGLE_Z_WIDTH = 34;

   function automatic logic [31:0] atan_entry(input logic [ATAN_INDEX_WIDTH-1:0] idx);
      logic [31:0] val;
      begin
         unique case (idx)
            6'd0: val = 32'd536870912;
            6'd1: val = 32'd316933406;
            6'd2: val = 32'd167458907;
            6'd3: val = 32'd85004756;
            6'd4: val = 32'd42667331;
            6'd5: val = 32'd21354465;
            6'd6: val = 32'd10679838;
            6'd7: val = 32'd5340245;
            6'd8: val = 32'd2670163;
            6'd9: val = 32'd1335087;
            6'd10: val = 32'd667544;
            6'd11: val = 32'd333772;
            6'd12: val = 32'd166886;
            6'd13: val = 32'd83443;
            6'd14: val = 32'd41722;
            6'd15: val = 32'd20861;
            6'd16: val = 32'd10430;
            6'd17: val = 32'd5215;
            6'd18: val = 32'd2608;
            6'd19: val = 32'd1304;
            6'd20: val = 32'd652;
            6'd21: val = 32'd326;
            6'd22: val = 32'd163;
            6'd23: val = 32'd81;
            6'd24: val = 32'd41;
            6'd25: val = 32'd20;
            6'd26: val = 32'd10;
            6'd27: val = 32'd5;
            6'd28: val = 32'd3;
            6'd29: val = 32'd1;
            6'd30: val = 32'd1;
            default: val = 32'd0;
         endcase
         return val;
      end
   endfunction
endpackage
`default_nettype wire

// ===== rtl/e2n_matrix.sv =====
// Reference angle registers, iterative CORDIC and rotation matrix builder.
`default_nettype none
module e2n_matrix #(
   parameter int ANGLE_WIDTH        = 32,
   parameter int TRIG_FRACTION_BITS = 30,
   parameter int CORDIC_STAGES      = 32,
   parameter int COEF_WIDTH         = 33
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic csr_valid,
   output logic      csr_ready,
   input  wire logic [e2n_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [e2n_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   output logic      busy,
   output logic signed [COEF_WIDTH-1:0] coef [9]
);
   localparam int CW    = COEF_WIDTH;
   localparam int ZW    = e2n_pkg::ANGLE_Z_WIDTH;
   localparam int CNTW  = $clog2(CORDIC_STAGES + 1);
   localparam int Sh    = 30 - TRIG_FRACTION_BITS;
   localparam longint GainRnd = (((e2n_pkg::GAIN_Q30 * 2) >> Sh) + 1) >> 1;
   localparam logic signed [CW-1:0] Gain = CW'(GainRnd);
   localparam logic signed [2*CW-1:0] QHalf = (2*CW)'(64'd1 << (TRIG_FRACTION_BITS - 1));

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOAD = 2'd1;
   localparam logic [1:0] ST_ITER = 2'd2;
   localparam logic [1:0] ST_MAT  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [ANGLE_WIDTH-1:0] lat_ff, lat_in, lon_ff, lon_in;
   logic signed [CW-1:0] x_ff [2];
   logic signed [CW-1:0] y_ff [2];
   logic signed [ZW-1:0] z_ff [2];
   logic flip_ff [2];
   logic signed [CW-1:0] q_ff [4];
   logic signed [CW-1:0] sn [2];
   logic signed [CW-1:0] cs [2];
   logic [31:0] atan_val;
   logic signed [CW-1:0] mul_a, mul_b;
   logic signed [2*CW-1:0] mul_p, mul_r;
   logic write_hit;

   assign busy      = state_ff != ST_IDLE;
   assign csr_ready = state_ff == ST_IDLE;
   assign write_hit = csr_valid && csr_ready &&
                      (csr_index == e2n_pkg::CSR_REF_LATITUDE ||
                       csr_index == e2n_pkg::CSR_REF_LONGITUDE);
   assign atan_val  = e2n_pkg::atan_entry(e2n_pkg::ATAN_INDEX_WIDTH'(cnt_ff));

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      lat_in   = lat_ff;
      lon_in   = lon_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (write_hit) begin
               if (csr_index == e2n_pkg::CSR_REF_LATITUDE) begin
                  lat_in = csr_data[ANGLE_WIDTH-1:0];
               end else begin
                  lon_in = csr_data[ANGLE_WIDTH-1:0];
               end
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cnt_in   = '0;
            state_in = ST_ITER;
         end
         ST_ITER: begin
            if (cnt_ff == CNTW'(CORDIC_STAGES - 1)) begin
               cnt_in   = '0;
               state_in = ST_MAT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_MAT: begin
            if (cnt_ff == CNTW'(3)) begin
               state_in = ST_IDLE;
            end
            cnt_in = cnt_ff + 1'b1;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         cnt_ff   <= '0;
         lat_ff   <= '0;
         lon_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         lat_ff   <= lat_in;
         lon_ff   <= lon_in;
      end
   end

   for (genvar ln = 0; ln < 2; ln++) begin : g_lane
      logic [31:0] a_scaled, a_fold;
      logic flip_in;
      logic signed [CW-1:0] dx, dy;

      assign a_scaled = 32'(ln == 0 ? lat_ff : lon_ff) << (32 - ANGLE_WIDTH);
      assign flip_in  = a_scaled[31] ^ a_scaled[30];
      assign a_fold   = flip_in ? (a_scaled ^ 32'h8000_0000) : a_scaled;
      assign dx       = y_ff[ln] >>> cnt_ff;
      assign dy       = x_ff[ln] >>> cnt_ff;
      assign sn[ln]   = flip_ff[ln] ? -y_ff[ln] : y_ff[ln];
      assign cs[ln]   = flip_ff[ln] ? -x_ff[ln] : x_ff[ln];

      always_ff @(posedge clock) begin
         if (state_ff == ST_LOAD) begin
            x_ff[ln]    <= Gain;
            y_ff[ln]    <= '0;
            z_ff[ln]    <= ZW'($signed(a_fold));
            flip_ff[ln] <= flip_in;
         end else if (state_ff == ST_ITER) begin
            if (!z_ff[ln][ZW-1]) begin
               x_ff[ln] <= x_ff[ln] - dx;
               y_ff[ln] <= y_ff[ln] + dy;
               z_ff[ln] <= z_ff[ln] - $signed(ZW'(atan_val));
            end else begin
               x_ff[ln] <= x_ff[ln] + dx;
               y_ff[ln] <= y_ff[ln] - dy;
               z_ff[ln] <= z_ff[ln] + $signed(ZW'(atan_val));
            end
         end
      end
   end

   assign mul_a = cnt_ff[1] ? cs[0] : sn[0];
   assign mul_b = cnt_ff[0] ? sn[1] : cs[1];
   assign mul_p = mul_a * mul_b;
   assign mul_r = (mul_p + QHalf) >>> TRIG_FRACTION_BITS;

   always_ff @(posedge clock) begin
      if (state_ff == ST_MAT) begin
         q_ff[cnt_ff[1:0]] <= -CW'(mul_r);
      end
   end

   assign coef[0] = q_ff[0];
   assign coef[1] = q_ff[1];
   assign coef[2] = cs[0];
   assign coef[3] = -sn[1];
   assign coef[4] = cs[1];
   assign coef[5] = '0;
   assign coef[6] = q_ff[2];
   assign coef[7] = q_ff[3];
   assign coef[8] = -sn[0];
endmodule
`default_nettype wire

// ===== rtl/ecef_to_ned_rotation_unit.sv =====
// Top level: ECEF to NED rotation with a four stage multiply pipeline.
//
//   channel | ports                          | direction | flow
//   request | start, busy, req_ecef_*        | in        | start && !busy
//   result  | rsp_strobe, rsp_*              | out       | one cycle strobe
//   config  | csr_valid, csr_ready, csr_*    | in        | valid && ready
//
// One item per cycle while busy is low; each result passes the half-product, product,
// row-sum and output registers in that order. After reset and after each angle write,
// busy is high while the iterative CORDIC and the shared matrix multiplier rebuild
// the coefficients. The receiver cannot stall, so the pipeline always advances.
`default_nettype none
module ecef_to_ned_rotation_unit #(
   parameter int VECTOR_WIDTH       = 40,
   parameter int ANGLE_WIDTH        = 32,
   parameter int TRIG_FRACTION_BITS = 30,
   parameter int CORDIC_STAGES      = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   output logic      busy,
   input  wire logic [VECTOR_WIDTH-1:0] req_ecef_x,
   input  wire logic [VECTOR_WIDTH-1:0] req_ecef_y,
   input  wire logic [VECTOR_WIDTH-1:0] req_ecef_z,
   output logic      rsp_strobe,
   output logic [VECTOR_WIDTH-1:0] rsp_north,
   output logic [VECTOR_WIDTH-1:0] rsp_east,
   output logic [VECTOR_WIDTH-1:0] rsp_down,
   output logic      rsp_clipped,
   input  wire logic csr_valid,
   output logic      csr_ready,
   input  wire logic [e2n_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [e2n_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);
   localparam int VW = VECTOR_WIDTH;
   localparam int CW = TRIG_FRACTION_BITS + 3;
   localparam int L  = VW / 2;
   localparam int H  = VW - L;
   localparam int PW = CW + VW;
   localparam int SW = PW + 2;
   localparam int RW = SW - TRIG_FRACTION_BITS;
   localparam logic signed [SW-1:0] HalfTerm = SW'(64'd1 << (TRIG_FRACTION_BITS - 1));
   localparam logic [VW-1:0] VMax = {1'b0, {(VW-1){1'b1}}};
   localparam logic [VW-1:0] VMin = {1'b1, {(VW-1){1'b0}}};

   logic signed [CW-1:0] coef [9];
   logic [VW-1:0] vin [3];
   logic accept;
   logic v1_ff, v2_ff, v3_ff;
   logic signed [CW+L:0] plo_ff [9];
   logic signed [CW+H-1:0] phi_ff [9];
   logic signed [PW-1:0] prod_ff [9];
   logic signed [SW-1:0] sum_ff [3];
   logic [VW-1:0] res_in [3];
   logic clip_in [3];
   logic rsp_strobe_ff, rsp_clipped_ff;
   logic [VW-1:0] rsp_north_ff, rsp_east_ff, rsp_down_ff;

   e2n_matrix #(
      .ANGLE_WIDTH(ANGLE_WIDTH),
      .TRIG_FRACTION_BITS(TRIG_FRACTION_BITS),
      .CORDIC_STAGES(CORDIC_STAGES),
      .COEF_WIDTH(CW)
   ) u_matrix (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .busy(busy),
      .coef(coef)
   );

   assign vin[0] = req_ecef_x;
   assign vin[1] = req_ecef_y;
   assign vin[2] = req_ecef_z;
   assign accept = start && !busy;

   for (genvar k = 0; k < 9; k++) begin : g_prod
      logic signed [CW+L:0] plo_in;
      logic signed [CW+H-1:0] phi_in;
      logic signed [PW-1:0] prod_in;

      assign plo_in  = coef[k] * $signed({1'b0, vin[k % 3][L-1:0]});
      assign phi_in  = coef[k] * $signed(vin[k % 3][VW-1:L]);
      assign prod_in = (PW'(phi_ff[k]) <<< L) + PW'(plo_ff[k]);

      always_ff @(posedge clock) begin
         plo_ff[k]  <= plo_in;
         phi_ff[k]  <= phi_in;
         prod_ff[k] <= prod_in;
      end
   end

   for (genvar r = 0; r < 3; r++) begin : g_row
      logic signed [SW-1:0] sum_in;
      logic signed [SW-1:0] shifted;
      logic [RW-1:0] rnd;
      logic [RW-VW:0] top;
      logic fit;

      assign sum_in  = SW'(prod_ff[3*r]) + SW'(prod_ff[3*r+1]) + SW'(prod_ff[3*r+2])
                       + HalfTerm;
      assign shifted = sum_ff[r] >>> TRIG_FRACTION_BITS;
      assign rnd     = shifted[RW-1:0];
      assign top     = rnd[RW-1:VW-1];
      assign fit     = (&top) || !(|top);
      assign res_in[r]  = fit ? rnd[VW-1:0] : (rnd[RW-1] ? VMin : VMax);
      assign clip_in[r] = !fit;

      always_ff @(posedge clock) begin
         sum_ff[r] <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         v1_ff         <= accept;
         v2_ff         <= v1_ff;
         v3_ff         <= v2_ff;
         rsp_strobe_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_north_ff   <= res_in[0];
      rsp_east_ff    <= res_in[1];
      rsp_down_ff    <= res_in[2];
      rsp_clipped_ff <= clip_in[0] || clip_in[1] || clip_in[2];
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_north   = rsp_north_ff;
   assign rsp_east    = rsp_east_ff;
   assign rsp_down    = rsp_down_ff;
   assign rsp_clipped = rsp_clipped_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_strobe)
      else $error("item did not produce a result after four cycles");

   a_rebuild: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready &&
       (csr_index == e2n_pkg::CSR_REF_LATITUDE ||
        csr_index == e2n_pkg::CSR_REF_LONGITUDE)) |=> busy)
      else $error("angle write did not start a coefficient rebuild");

   a_clip: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_clipped) |->
         (rsp_north == VMax || rsp_north == VMin || rsp_east == VMax ||
          rsp_east == VMin || rsp_down == VMax || rsp_down == VMin))
      else $error("clip flag set with no saturated component");
endmodule
`default_nettype wire

// ===== dv/e2n_checker.sv =====
// Checker for the ECEF to NED rotation unit: predicts each rotated vector and compares.
`timescale 1ns / 100ps
module e2n_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire logic [39:0] req_ecef_x,
   input  wire logic [39:0] req_ecef_y,
   input  wire logic [39:0] req_ecef_z,
   input  wire logic        rsp_strobe,
   input  wire logic [39:0] rsp_north,
   input  wire logic [39:0] rsp_east,
   input  wire logic [39:0] rsp_down,
   input  wire logic        rsp_clipped,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [e2n_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [e2n_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   output int               fail_count,
   output int               pending
);
   typedef struct packed {
      logic [39:0] north;
      logic [39:0] east;
      logic [39:0] down;
      logic        clipped;
   } ned_type;

   localparam longint CORDIC_GAIN = 652032874;
   localparam longint ARCTAN [32] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
      10, 5, 3, 1, 1, 0};

   logic [31:0] latitude;
   logic [31:0] longitude;
   longint      rot [3][3];
   ned_type     ned_q [$];

   function automatic void sin_cos(input logic [31:0] ang, output longint s,
                                   output longint c);
      logic [31:0] a;
      logic [31:0] probe;
      logic        flip;
      longint      x, y, z, dx, dy;
      a = ang;
      probe = a + 32'h4000_0000;
      flip = probe[31];
      if (flip) a = a + 32'h8000_0000;
      z = longint'($signed(a));
      x = CORDIC_GAIN;
      y = 0;
      for (int i = 0; i < 32; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx; y = y + dy; z = z - ARCTAN[i];
         end else begin
            x = x + dx; y = y - dy; z = z + ARCTAN[i];
         end
      end
      if (flip) begin
         x = -x; y = -y;
      end
      s = y;
      c = x;
   endfunction

   function automatic longint qmul(input longint a, input longint b);
      return (a * b + (longint'(1) <<< 29)) >>> 30;
   endfunction

   task automatic rebuild_matrix();
      longint sla, cla, slo, clo;
      sin_cos(latitude, sla, cla);
      sin_cos(longitude, slo, clo);
      rot[0][0] = -qmul(sla, clo); rot[0][1] = -qmul(sla, slo); rot[0][2] = cla;
      rot[1][0] = -slo;            rot[1][1] = clo;             rot[1][2] = 0;
      rot[2][0] = -qmul(cla, clo); rot[2][1] = -qmul(cla, slo); rot[2][2] = -sla;
   endtask

   function automatic ned_type rotate(input logic [39:0] vx, input logic [39:0] vy,
                                      input logic [39:0] vz);
      logic signed [127:0] acc, m, v, vmax, vmin;
      logic [39:0]         comp [3];
      ned_type             r;
      vmax = (128'sd1 <<< 39) - 1;
      vmin = -(128'sd1 <<< 39);
      r.clipped = 1'b0;
      for (int row = 0; row < 3; row++) begin
         acc = 0;
         for (int col = 0; col < 3; col++) begin
            m = rot[row][col];
            v = (col == 0) ? $signed(vx) : (col == 1) ? $signed(vy) : $signed(vz);
            acc = acc + m * v;
         end
         acc = (acc + (128'sd1 <<< 29)) >>> 30;
         if (acc > vmax) begin
            acc = vmax; r.clipped = 1'b1;
         end else if (acc < vmin) begin
            acc = vmin; r.clipped = 1'b1;
         end
         comp[row] = acc[39:0];
      end
      r.north = comp[0];
      r.east  = comp[1];
      r.down  = comp[2];
      return r;
   endfunction

   always @(posedge clock) begin
      ned_type got, want;
      if (reset) begin
         latitude  = '0;
         longitude = '0;
         rebuild_matrix();
         ned_q.delete();
         fail_count <= 0;
      end else begin
         if (rsp_strobe) begin
            got = '{rsp_north, rsp_east, rsp_down, rsp_clipped};
            if (ned_q.size() == 0) begin
               $display("%0t: unexpected result %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = ned_q.pop_front();
               if (got.north !== want.north || got.east !== want.east ||
                   got.down !== want.down || got.clipped !== want.clipped) begin
                  $display("%0t: mismatch expected n=%h e=%h d=%h c=%b", $time,
                           want.north, want.east, want.down, want.clipped);
                  $display("%0t:          actual   n=%h e=%h d=%h c=%b", $time,
                           got.north, got.east, got.down, got.clipped);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (start && !busy) ned_q.push_back(rotate(req_ecef_x, req_ecef_y, req_ecef_z));
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               e2n_pkg::CSR_REF_LATITUDE: begin
                  latitude = csr_data;
                  rebuild_matrix();
               end
               e2n_pkg::CSR_REF_LONGITUDE: begin
                  longitude = csr_data;
                  rebuild_matrix();
               end
               default: ;
            endcase
         end
      end
      pending <= ned_q.size();
   end
endmodule

// ===== dv/tb.sv =====
// Testbench top for the ECEF to NED rotation unit: stimulus, configuration phases and verdict.
`timescale 1ns / 100ps
module tb;
   logic        clock;
   logic        reset;
   logic        start;
   logic [39:0] req_ecef_x, req_ecef_y, req_ecef_z;
   logic        csr_valid;
   logic [e2n_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [e2n_pkg::CSR_DATA_WIDTH-1:0]  csr_data;
   wire         busy, rsp_strobe, rsp_clipped, csr_ready;
   wire  [39:0] rsp_north, rsp_east, rsp_down;
   int          fail_count, pending;
   int          vectors_sent;
   int          idle_pct;

   ecef_to_ned_rotation_unit dut (
      .clock, .reset, .start, .busy, .req_ecef_x, .req_ecef_y, .req_ecef_z,
      .rsp_strobe, .rsp_north, .rsp_east, .rsp_down, .rsp_clipped,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   e2n_checker u_checker (
      .clock, .reset, .start, .busy, .req_ecef_x, .req_ecef_y, .req_ecef_z,
      .rsp_strobe, .rsp_north, .rsp_east, .rsp_down, .rsp_clipped,
      .csr_valid, .csr_ready, .csr_index, .csr_data, .fail_count, .pending
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("timeout");
      $display("Regression FAIL");
      $finish;
   end

   function automatic logic [39:0] pick_component();
      logic [39:0] v;
      case ($urandom_range(0, 7))
         0: v = 40'h7F_FFFF_FFFF;
         1: v = 40'h80_0000_0000;
         2: v = 40'($signed($urandom_range(0, 2000)) - 1000);
         3: v = 40'($signed($urandom()) >>> $urandom_range(0, 12));
         default: v = 40'({$urandom(), $urandom()});
      endcase
      return v;
   endfunction

   task automatic send_vector(input logic [39:0] vx, input logic [39:0] vy,
                              input logic [39:0] vz);
      start      <= 1'b1;
      req_ecef_x <= vx;
      req_ecef_y <= vy;
      req_ecef_z <= vz;
      #0;
      while (busy) @(negedge clock);
      @(negedge clock);
      vectors_sent++;
      if ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
   endtask

   task automatic write_csr(input logic [e2n_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            input logic [e2n_pkg::CSR_DATA_WIDTH-1:0] val);
      start     <= 1'b0;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      #0;
      while (!csr_ready) @(negedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (50) @(negedge clock);
   endtask

   task automatic random_vectors(input int count);
      for (int n = 0; n < count; n++)
         send_vector(pick_component(), pick_component(), pick_component());
   endtask

   initial begin
      logic [39:0] vmax, vmin;
      vmax = 40'h7F_FFFF_FFFF;
      vmin = 40'h80_0000_0000;
      reset = 1'b1; start = 1'b0; csr_valid = 1'b0;
      csr_index = '0; csr_data = '0;
      req_ecef_x = '0; req_ecef_y = '0; req_ecef_z = '0;
      vectors_sent = 0;
      idle_pct = 27;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_vector('0, '0, '0);
      send_vector(vmax, vmax, vmax);
      send_vector(vmin, vmin, vmin);
      send_vector(vmax, vmin, vmax);
      send_vector(40'd1, 40'd1, 40'd1);
      send_vector('1, '1, '1);
      send_vector(40'h55_5555_5555, 40'hAA_AAAA_AAAA, 40'h55_5555_5555);
      drain();

      write_csr(e2n_pkg::CSR_REF_LATITUDE, 32'h2000_0000);
      write_csr(e2n_pkg::CSR_REF_LONGITUDE, 32'h2000_0000);
      send_vector(vmax, vmax, vmax);
      send_vector(vmin, vmin, vmin);
      send_vector(vmax, vmax, vmin);
      send_vector(vmin, vmin, vmax);
      send_vector(40'h00_4000_0000, 40'hFF_C000_0000, 40'd3);
      random_vectors(230);
      drain();

      write_csr(e2n_pkg::CSR_REF_LATITUDE, 32'h4000_0000);
      write_csr(e2n_pkg::CSR_REF_LONGITUDE, 32'h0000_0000);
      random_vectors(240);
      drain();

      write_csr(e2n_pkg::CSR_REF_LATITUDE, 32'hC000_0000);
      write_csr(e2n_pkg::CSR_REF_LONGITUDE, 32'h7FFF_FFFF);
      random_vectors(240);
      drain();

      idle_pct = 0;
      write_csr(e2n_pkg::CSR_REF_LATITUDE, 32'h7FFF_FFFF);
      write_csr(e2n_pkg::CSR_REF_LONGITUDE, 32'h8000_0000);
      random_vectors(240);
      drain();
      idle_pct = 27;

      write_csr(8'hFF, 32'h1234_5678);
      write_csr(e2n_pkg::CSR_INDEX_WIDTH'($urandom_range(2, 254)), $urandom());
      random_vectors(120);
      drain();

      for (int p = 0; p < 4; p++) begin
         write_csr(e2n_pkg::CSR_REF_LATITUDE,
                   (p == 0) ? 32'hFFFF_FFFF : 32'($urandom_range(0, 32'h8000_0000)) - 32'h4000_0000);
         write_csr(e2n_pkg::CSR_REF_LONGITUDE, (p == 0) ? 32'h0000_0001 : $urandom());
         random_vectors(210);
         drain();
      end

      $display("Covered %0d vectors over nine angle settings: poles, beyond-pole latitude,", vectors_sent);
      $display("longitude wrap, ignored register indexes and saturating extremes.");
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

// ===== ecef_to_ned_rotation_unit.f =====
rtl/e2n_pkg.sv
rtl/e2n_matrix.sv
rtl/ecef_to_ned_rotation_unit.sv
dv/e2n_checker.sv
dv/tb.sv
